>>> rtl/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

	localparam int unsigned CmdW = 3;
	localparam int unsigned ByteW = 8;
	localparam int unsigned PhaseW = 5;
	localparam int unsigned PaddrW = 3;
	localparam int unsigned PdataW = 32;
	localparam logic [ByteW-1:0] AckLimitReset = 8'd255;
	localparam logic [PhaseW-1:0] WriteLastBit = 5'd24;
	localparam logic [PhaseW-1:0] ReadLast = 5'd16;
	localparam logic [PhaseW-1:0] WriteLast = 5'd25;

	typedef enum logic [CmdW-1:0] {
		OP_IDLE  = 3'd0,
		OP_INIT  = 3'd1,
		OP_START = 3'd2,
		OP_STOP  = 3'd3,
		OP_WRITE = 3'd4,
		OP_READ  = 3'd5,
		OP_ACK   = 3'd6
	} op_t;

	typedef enum logic {
		REG_ACK_LIMIT = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic [ByteW-1:0] write_byte;
		logic             sda_line;
	} in_beat_t;

	typedef struct packed {
		logic             scl_level;
		logic             sda_level;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] read_result;
		logic             ack_seen;
	} out_beat_t;

endpackage
`default_nettype wire

>>> rtl/i2c_master_tick_engine_top.sv
// the result beat of an accepted tick beat is registered and appears in the next cycle
// throughput: one tick beat per cycle while the result side does not stall
// the output register sets the rate; a stalled result stalls the input side
// reset (arst_n low): idle, both lines released, read byte and ack flag zero,
// ack_wait_limit 255
`default_nettype none
module i2c_master_tick_engine_top
	import i2cm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_beat_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_beat_t                  out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PaddrW-1:0]     paddr,
	input  wire logic [PdataW-1:0]     pwdata,
	output logic [PdataW-1:0]          prdata,
	output logic                       pready
);

	logic [ByteW-1:0]  ack_limit_q;
	op_t               op_q, op_n, op_c;
	logic [PhaseW-1:0] phase_q, phase_n, phase_c;
	logic [1:0]        sub_q, sub_n, sub_c;
	logic [ByteW-1:0]  shift_q, shift_n, shift_c;
	logic [ByteW-1:0]  poll_q, poll_n, poll_c;
	logic              scl_q, scl_n;
	logic              sda_q, sda_n;
	logic              ack_q, ack_n;
	logic [ByteW-1:0]  rdval_q, rdval_n;
	logic              done_c;
	logic              start_c;
	logic              accept;
	logic              out_valid_q;
	out_beat_t         out_q;
	reg_idx_t          cfg_idx;

	// config port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_limit_q <= AckLimitReset;
		end else if (psel && penable && pwrite && pready && cfg_idx == REG_ACK_LIMIT) begin
			ack_limit_q <= pwdata[ByteW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_ACK_LIMIT: prdata = {{(PdataW-ByteW){1'b0}}, ack_limit_q};
			default:       prdata = '0;
		endcase
	end

	// handshake
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// command launch
	always_comb begin
		start_c = (op_q == OP_IDLE) && (in_data.command >= OP_INIT)
			&& (in_data.command <= OP_ACK);
		op_c    = start_c ? op_t'(in_data.command) : op_q;
		phase_c = start_c ? '0 : phase_q;
		sub_c   = start_c ? '0 : sub_q;
		poll_c  = start_c ? '0 : poll_q;
		shift_c = shift_q;
		if (start_c && in_data.command == OP_WRITE) begin
			shift_c = in_data.write_byte;
		end else if (start_c && in_data.command == OP_READ) begin
			shift_c = '0;
		end
	end

	// line levels and datapath
	always_comb begin
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		rdval_n = rdval_q;
		shift_n = shift_c;
		poll_n  = poll_c;
		sub_n   = sub_c;
		done_c  = 1'b0;
		unique case (op_c)
			OP_INIT: begin
				scl_n  = 1'b1;
				sda_n  = 1'b1;
				done_c = 1'b1;
			end
			OP_START: begin
				if (phase_c == 5'd0) begin
					scl_n = 1'b1;
					sda_n = 1'b1;
				end else if (phase_c == 5'd1) begin
					sda_n = 1'b0;
				end else begin
					scl_n  = 1'b0;
					done_c = 1'b1;
				end
			end
			OP_STOP: begin
				if (phase_c == 5'd0) begin
					scl_n = 1'b0;
					sda_n = 1'b0;
				end else if (phase_c == 5'd1) begin
					scl_n = 1'b1;
				end else begin
					sda_n  = 1'b1;
					done_c = 1'b1;
				end
			end
			OP_WRITE: begin
				if (phase_c == 5'd0) begin
					scl_n = 1'b0;
				end else if (phase_c <= WriteLastBit) begin
					sub_n = (sub_c == 2'd2) ? 2'd0 : sub_c + 2'd1;
					if (sub_c == 2'd0) begin
						sda_n   = shift_c[ByteW-1];
						shift_n = {shift_c[ByteW-2:0], 1'b0};
					end else if (sub_c == 2'd1) begin
						scl_n = 1'b1;
					end else begin
						scl_n = 1'b0;
					end
				end else begin
					sda_n  = 1'b1;
					done_c = 1'b1;
				end
			end
			OP_READ: begin
				if (phase_c == 5'd0) begin
					scl_n = 1'b0;
					sda_n = 1'b1;
				end else if (phase_c[0]) begin
					scl_n   = 1'b1;
					shift_n = {shift_c[ByteW-2:0], in_data.sda_line};
				end else begin
					scl_n = 1'b0;
					if (phase_c >= ReadLast) begin
						rdval_n = shift_c;
						done_c  = 1'b1;
					end
				end
			end
			OP_ACK: begin
				if (phase_c == 5'd0) begin
					scl_n = 1'b1;
					sda_n = 1'b1;
				end else if (phase_c == 5'd1) begin
					scl_n = 1'b1;
					if (!in_data.sda_line) begin
						ack_n = 1'b1;
					end else if (poll_c >= ack_limit_q) begin
						ack_n = 1'b0;
					end else begin
						poll_n = poll_c + 8'd1;
					end
				end else begin
					scl_n  = 1'b0;
					done_c = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next operation and phase
	always_comb begin
		op_n    = op_c;
		phase_n = phase_c;
		if (op_c != OP_IDLE) begin
			if (done_c) begin
				op_n    = OP_IDLE;
				phase_n = '0;
			end else if (op_c == OP_ACK && phase_c == 5'd1) begin
				phase_n = (in_data.sda_line && poll_c >= ack_limit_q) ? 5'd2 :
					(!in_data.sda_line ? 5'd2 : 5'd1);
			end else begin
				phase_n = phase_c + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			phase_q <= '0;
			sub_q   <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rdval_q <= '0;
		end else if (accept) begin
			op_q    <= op_n;
			phase_q <= phase_n;
			sub_q   <= sub_n;
			shift_q <= shift_n;
			poll_q  <= poll_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rdval_q <= rdval_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.scl_level   <= scl_n;
			out_q.sda_level   <= sda_n;
			out_q.busy_res    <= (op_n != OP_IDLE);
			out_q.done_res    <= done_c;
			out_q.read_result <= rdval_n;
			out_q.ack_seen    <= ack_n;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.done_res |-> !out_q.busy_res)
		else $error("done beat still busy");

	a_read_phase: assert property (@(posedge clk) disable iff (!arst_n)
		op_q == OP_READ |-> phase_q <= ReadLast)
		else $error("read phase overrun");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		op_q == OP_WRITE |-> phase_q <= WriteLast)
		else $error("write phase overrun");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result lost");

endmodule
`default_nettype wire
